// ----- src/bpc_pkg.sv -----
package bpc_pkg;

  // Fixed field widths.
  localparam int RawW = 24;
  localparam int ScaleW = 24;
  localparam int OutW = 32;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW = 3;

  // Symmetric saturation limit of all intermediate values.
  localparam logic signed [63:0] Sat64 = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef logic signed [63:0] s64_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_LO  = 3'd0,
    CFG_COEF_MID = 3'd1,
    CFG_COEF_HI  = 3'd2,
    CFG_P_SCALE  = 3'd3,
    CFG_T_SCALE  = 3'd4
  } cfg_idx_e;

  // Absolute value of a 64-bit signed word as unsigned.
  function automatic logic [63:0] magnitude(input s64_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

endpackage

// ----- src/bpc_if.sv -----
interface bpc_in_if;
  import bpc_pkg::*;
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_pressure;
  logic [RawW-1:0] raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] temperature_q16;
  logic signed [OutW-1:0] pressure_q8;
  modport source (output valid, temperature_q16, pressure_q8, input ready);
  modport sink (input valid, temperature_q16, pressure_q8, output ready);
endinterface

// ----- src/bpc_mulsh.sv -----
// Three-stage signed multiply with rounded right shift and saturation.
module bpc_mulsh
  import bpc_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  s64_t a_i,
  input  s64_t b_i,
  output s64_t p_o
);

  localparam logic [127:0] Rnd = (SHIFT > 0) ? (128'(1) << (SHIFT - 1)) : 128'(0);

  logic [63:0]  ua, ub;
  logic         neg1_q, neg2_q;
  logic [63:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [127:0] prod_q;
  logic [127:0] rnd_sum, shifted;
  logic [63:0]  mag;

  assign ua = magnitude(a_i);
  assign ub = magnitude(b_i);

  // Result magnitude after rounding, saturated to the 63-bit limit.
  assign rnd_sum = prod_q + Rnd;
  assign shifted = rnd_sum >> SHIFT;
  assign mag = (shifted[127:63] != '0) ? 64'(Sat64) : shifted[63:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage one: four 32 by 32 partial products.
      neg1_q <= a_i[63] ^ b_i[63];
      pp00_q <= ua[31:0] * ub[31:0];
      pp01_q <= ua[31:0] * ub[63:32];
      pp10_q <= ua[63:32] * ub[31:0];
      pp11_q <= ua[63:32] * ub[63:32];
      // Stage two: full 128-bit product.
      neg2_q <= neg1_q;
      prod_q <= {64'd0, pp00_q} + ({64'd0, pp01_q} << 32) + ({64'd0, pp10_q} << 32)
                + {pp11_q, 64'd0};
      // Stage three: round, shift, saturate and restore the sign.
      p_o    <= neg2_q ? -s64_t'(mag) : s64_t'(mag);
    end
  end

endmodule

// ----- src/baro_pressure_temp_compensation.sv -----
// Barometric pressure and temperature compensation. Each transaction on
// sample_i carries one raw pressure and temperature pair and yields one
// transaction on result_o with compensated temperature and pressure. The
// datapath is a single pipeline that takes a new pair every cycle. It is
// SCALED_FRAC_BITS + 41 register stages deep. The depth is set by the
// restoring dividers (one quotient bit per stage) and by four rounds of
// three-stage multipliers for the pressure polynomial. The whole pipeline
// holds while a result waits. Calibration bytes and scale factors must be
// written through the cfg port only while no transaction is in flight; the
// block itself does not enforce this.
module baro_pressure_temp_compensation
  import bpc_pkg::*;
#(
  parameter int SCALED_FRAC_BITS = 24,
  parameter int TEMP_FRAC_BITS = 16,
  parameter int PRESS_FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bpc_in_if.sink              sample_i,
  bpc_out_if.source           result_o
);

  localparam int SF = SCALED_FRAC_BITS;
  localparam int NW = RawW + SF;
  localparam int LAT = NW + 17;
  localparam int TRsh = (SF >= TEMP_FRAC_BITS) ? SF - TEMP_FRAC_BITS : 0;
  localparam int TLsh = (SF >= TEMP_FRAC_BITS) ? 0 : TEMP_FRAC_BITS - SF;
  localparam int PRsh = (SF >= PRESS_FRAC_BITS) ? SF - PRESS_FRAC_BITS : 0;
  localparam int PLsh = (SF >= PRESS_FRAC_BITS) ? 0 : PRESS_FRAC_BITS - SF;

  // Saturating 64-bit add.
  function automatic s64_t sat_add(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(Sat64)) return Sat64;
    if (s < -65'(Sat64)) return -Sat64;
    return s64_t'(s);
  endfunction

  // Move to the output fraction bits, round, and clamp to 32 bits.
  function automatic logic [OutW-1:0] requant(input s64_t x, input int rsh, input int lsh);
    logic [127:0] w;
    logic [127:0] rnd;
    rnd = (rsh > 0) ? (128'(1) << (rsh - 1)) : 128'(0);
    w = (({64'd0, magnitude(x)} + rnd) >> rsh) << lsh;
    if (!x[63]) begin
      if (w > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return w[31:0];
    end
    if (w > 128'h8000_0000) return 32'h8000_0000;
    return 32'(-w[31:0]);
  endfunction

  // Configuration registers.
  logic [63:0]       coef_lo_q, coef_mid_q;
  logic [39:0]       coef_hi_q;
  logic [ScaleW-1:0] p_scale_q, t_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_lo_q  <= '0;
      coef_mid_q <= '0;
      coef_hi_q  <= '0;
      p_scale_q  <= ScaleW'(253952);
      t_scale_q  <= ScaleW'(524288);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_LO:  coef_lo_q <= cfg_data_i;
        CFG_COEF_MID: coef_mid_q <= cfg_data_i;
        CFG_COEF_HI:  coef_hi_q <= cfg_data_i[39:0];
        CFG_P_SCALE:  p_scale_q <= cfg_data_i[ScaleW-1:0];
        CFG_T_SCALE:  t_scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient unpacking; byte 0 sits at the top of the vector.
  logic [167:0] cal;
  s64_t c0h, c1, c00one, c10, c01one, c11, c20, c21, c30, c31, c40;

  assign cal    = {coef_lo_q, coef_mid_q, coef_hi_q};
  assign c0h    = 64'($signed(cal[167:156])) <<< (SF - 1);
  assign c1     = 64'($signed(cal[155:144]));
  assign c00one = 64'($signed(cal[143:124])) <<< SF;
  assign c10    = 64'($signed(cal[123:104]));
  assign c01one = 64'($signed(cal[103:88])) <<< SF;
  assign c11    = 64'($signed(cal[87:72]));
  assign c20    = 64'($signed(cal[71:56]));
  assign c21    = 64'($signed(cal[55:40]));
  assign c30    = 64'($signed(cal[39:24]));
  assign c31    = 64'($signed(cal[23:12]));
  assign c40    = 64'($signed(cal[11:0]));

  // Global pipeline enable and valid bits.
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en = !vld_q[LAT-1] || result_o.ready;
  assign sample_i.ready = en;
  assign result_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], sample_i.valid};
    end
  end

  // Divider preparation: magnitude, shifted numerator and half-divisor rounding.
  logic [ScaleW-1:0] pdiv, tdiv;
  logic [RawW-1:0]   pmag, tmag;
  logic [NW-1:0]     pw_q [NW+1];
  logic [NW-1:0]     tw_q [NW+1];
  logic [ScaleW-1:0] prem_q [NW+1];
  logic [ScaleW-1:0] trem_q [NW+1];
  logic              psg_q [NW+1];
  logic              tsg_q [NW+1];

  assign pdiv = (p_scale_q == '0) ? ScaleW'(1) : p_scale_q;
  assign tdiv = (t_scale_q == '0) ? ScaleW'(1) : t_scale_q;
  assign pmag = sample_i.raw_pressure[RawW-1] ? RawW'(-sample_i.raw_pressure)
                                              : sample_i.raw_pressure;
  assign tmag = sample_i.raw_temperature[RawW-1] ? RawW'(-sample_i.raw_temperature)
                                                 : sample_i.raw_temperature;

  always_ff @(posedge clk_i) begin
    if (en) begin
      psg_q[0]  <= sample_i.raw_pressure[RawW-1];
      tsg_q[0]  <= sample_i.raw_temperature[RawW-1];
      pw_q[0]   <= {pmag, SF'(0)} + NW'(pdiv >> 1);
      tw_q[0]   <= {tmag, SF'(0)} + NW'(tdiv >> 1);
      prem_q[0] <= '0;
      trem_q[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage for both channels.
  for (genvar k = 1; k <= NW; k++) begin : g_div
    logic [ScaleW:0] pt, tt;
    logic            pge, tge;
    assign pt  = {prem_q[k-1], pw_q[k-1][NW-1]};
    assign tt  = {trem_q[k-1], tw_q[k-1][NW-1]};
    assign pge = pt >= {1'b0, pdiv};
    assign tge = tt >= {1'b0, tdiv};
    always_ff @(posedge clk_i) begin
      if (en) begin
        psg_q[k]  <= psg_q[k-1];
        tsg_q[k]  <= tsg_q[k-1];
        prem_q[k] <= pge ? ScaleW'(pt - {1'b0, pdiv}) : pt[ScaleW-1:0];
        trem_q[k] <= tge ? ScaleW'(tt - {1'b0, tdiv}) : tt[ScaleW-1:0];
        pw_q[k]   <= {pw_q[k-1][NW-2:0], pge};
        tw_q[k]   <= {tw_q[k-1][NW-2:0], tge};
      end
    end
  end

  // Scaled values, polynomial products and accumulation.
  s64_t psc_q, tsc_q;
  s64_t psc_dl_q [3];
  s64_t tsc_dl_q [10];
  s64_t p2, m10, m11, mct, p3, p4, m20, m21, m30, m40, m31, mti;
  s64_t sp1_q, si1_q, sp2_q, si2_q, sp3_q, si3_q, sp4_q, m40_q, pf_q, t_q;
  s64_t sp1_dl_q [2];
  s64_t si1_dl_q [2];
  s64_t sp2_dl_q [2];
  s64_t si2_dl_q [2];
  s64_t sp4_dl_q [2];
  s64_t t_dl_q [10];
  logic [OutW-1:0] tout_q, pout_q;

  // First round: Psc squared and the linear terms.
  bpc_mulsh #(.SHIFT(SF)) u_p2 (.clk_i, .en_i(en), .a_i(psc_q), .b_i(psc_q), .p_o(p2));
  bpc_mulsh #(.SHIFT(0)) u_m10 (.clk_i, .en_i(en), .a_i(c10), .b_i(psc_q), .p_o(m10));
  bpc_mulsh #(.SHIFT(0)) u_m11 (.clk_i, .en_i(en), .a_i(c11), .b_i(psc_q), .p_o(m11));
  bpc_mulsh #(.SHIFT(0)) u_mct (.clk_i, .en_i(en), .a_i(c1), .b_i(tsc_q), .p_o(mct));
  // Second round: cube, fourth power and the square terms.
  bpc_mulsh #(.SHIFT(SF)) u_p3 (.clk_i, .en_i(en), .a_i(p2), .b_i(psc_dl_q[2]), .p_o(p3));
  bpc_mulsh #(.SHIFT(SF)) u_p4 (.clk_i, .en_i(en), .a_i(p2), .b_i(p2), .p_o(p4));
  bpc_mulsh #(.SHIFT(0)) u_m20 (.clk_i, .en_i(en), .a_i(c20), .b_i(p2), .p_o(m20));
  bpc_mulsh #(.SHIFT(0)) u_m21 (.clk_i, .en_i(en), .a_i(c21), .b_i(p2), .p_o(m21));
  // Third round: cube and fourth-power terms.
  bpc_mulsh #(.SHIFT(0)) u_m30 (.clk_i, .en_i(en), .a_i(c30), .b_i(p3), .p_o(m30));
  bpc_mulsh #(.SHIFT(0)) u_m40 (.clk_i, .en_i(en), .a_i(c40), .b_i(p4), .p_o(m40));
  bpc_mulsh #(.SHIFT(0)) u_m31 (.clk_i, .en_i(en), .a_i(c31), .b_i(p3), .p_o(m31));
  // Fourth round: temperature cross term.
  bpc_mulsh #(.SHIFT(SF)) u_mti (.clk_i, .en_i(en), .a_i(tsc_dl_q[9]), .b_i(si3_q),
                                 .p_o(mti));

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Apply the sign to the quotients.
      psc_q <= psg_q[NW] ? -s64_t'(pw_q[NW]) : s64_t'(pw_q[NW]);
      tsc_q <= tsg_q[NW] ? -s64_t'(tw_q[NW]) : s64_t'(tw_q[NW]);
      psc_dl_q[0] <= psc_q;
      tsc_dl_q[0] <= tsc_q;
      for (int i = 1; i < 3; i++) psc_dl_q[i] <= psc_dl_q[i-1];
      for (int i = 1; i < 10; i++) tsc_dl_q[i] <= tsc_dl_q[i-1];
      // Accumulation in the order the sums are defined.
      sp1_q <= sat_add(c00one, m10);
      si1_q <= sat_add(c01one, m11);
      t_q   <= sat_add(c0h, mct);
      sp1_dl_q[0] <= sp1_q;
      sp1_dl_q[1] <= sp1_dl_q[0];
      si1_dl_q[0] <= si1_q;
      si1_dl_q[1] <= si1_dl_q[0];
      sp2_q <= sat_add(sp1_dl_q[1], m20);
      si2_q <= sat_add(si1_dl_q[1], m21);
      sp2_dl_q[0] <= sp2_q;
      sp2_dl_q[1] <= sp2_dl_q[0];
      si2_dl_q[0] <= si2_q;
      si2_dl_q[1] <= si2_dl_q[0];
      sp3_q <= sat_add(sp2_dl_q[1], m30);
      si3_q <= sat_add(si2_dl_q[1], m31);
      m40_q <= m40;
      sp4_q <= sat_add(sp3_q, m40_q);
      sp4_dl_q[0] <= sp4_q;
      sp4_dl_q[1] <= sp4_dl_q[0];
      pf_q <= sat_add(sp4_dl_q[1], mti);
      t_dl_q[0] <= t_q;
      for (int i = 1; i < 10; i++) t_dl_q[i] <= t_dl_q[i-1];
      // Output register.
      tout_q <= requant(t_dl_q[9], TRsh, TLsh);
      pout_q <= requant(pf_q, PRsh, PLsh);
    end
  end

  assign result_o.temperature_q16 = tout_q;
  assign result_o.pressure_q8     = pout_q;

endmodule

// ----- src/bpc_checker.sv -----
// Port-level checks of the compensation block.
module bpc_checker
  import bpc_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            smp_valid_i,
  input logic            smp_ready_i,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input logic [OutW-1:0] res_temp_i,
  input logic [OutW-1:0] res_press_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_temp_i)
    && $stable(res_press_i))
    else $error("stalled result changed");

  // With no result pending the pipeline takes input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> smp_ready_i)
    else $error("input refused with empty output");

  // A stalled result holds the input side too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !smp_ready_i)
    else $error("input taken during output stall");

  // An offered input transaction stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i && !smp_ready_i |=> smp_valid_i)
    else $error("input withdrawn before it was taken");

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .smp_valid_i (sample_i.valid),
  .smp_ready_i (sample_i.ready),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_temp_i  (result_o.temperature_q16),
  .res_press_i (result_o.pressure_q8)
);

// ----- dv/baro_pressure_temp_compensation_tb.sv -----
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_tb;
  import bpc_pkg::*;

  localparam int FracBits = 24;
  localparam int TempFrac = 16;
  localparam int PressFrac = 8;
  localparam int PipeDepth = FracBits + 41;
  localparam int RandomPhases = 14;
  localparam int ItemsPerPhase = 110;
  localparam int HoldCycles = 400;
  // Index that names no register; a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  typedef struct packed {
    logic signed [OutW-1:0] temp;
    logic signed [OutW-1:0] press;
  } reading_t;

  typedef struct {
    logic [RawW-1:0] raw_p;
    logic [RawW-1:0] raw_t;
  } raw_pair_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bpc_in_if  sample_if ();
  bpc_out_if result_if ();

  baro_pressure_temp_compensation uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if.sink),
    .result_o   (result_if.source)
  );

  // Shadow copy of the calibration and scale registers.
  logic [63:0] cal_lo, cal_mid;
  logic [39:0] cal_hi;
  logic [23:0] p_scale, t_scale;

  reading_t expected_readings[$];
  int unsigned errors;
  bit quote_zero;   // coefficients are all zero, so every reading is zero
  bit sender_idles, receiver_idles;
  int unsigned hold_request;

  // Directed raw values, among them zero, one, both signed extremes and minus one.
  raw_pair_t corner_rows[12] = '{
    '{24'h000000, 24'h000000}, '{24'h000001, 24'h000001},
    '{24'h7FFFFF, 24'h7FFFFF}, '{24'h800000, 24'h800000},
    '{24'hFFFFFF, 24'hFFFFFF}, '{24'h7FFFFF, 24'h800000},
    '{24'h800000, 24'h7FFFFF}, '{24'h000000, 24'h7FFFFF},
    '{24'h7FFFFF, 24'h000000}, '{24'hAAAAAA, 24'h555555},
    '{24'h555555, 24'hAAAAAA}, '{24'h03E000, 24'hFC0000}
  };

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Product of two signed words shifted right with rounding half away
  // from zero, saturated symmetrically to the 64-bit limit.
  function automatic s64_t mul_round(input s64_t a, input s64_t b, input int sh);
    logic neg;
    logic [63:0] ua, ub, mag;
    logic [127:0] prod;
    neg = a[63] ^ b[63];
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = b[63] ? 64'(-b) : 64'(b);
    prod = 128'(ua) * 128'(ub);
    if (sh > 0) begin
      prod = prod + (128'(1) << (sh - 1));
    end
    prod = prod >> sh;
    mag = (prod > 128'(Sat64)) ? Sat64 : prod[63:0];
    return neg ? -s64_t'(mag) : s64_t'(mag);
  endfunction

  function automatic s64_t add_clamp(input s64_t a, input s64_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(Sat64)) return Sat64;
    if (s < -65'(Sat64)) return -Sat64;
    return s[63:0];
  endfunction

  function automatic logic [7:0] cal_byte(input int k);
    if (k < 8) return cal_lo[63 - 8 * k -: 8];
    if (k < 16) return cal_mid[63 - 8 * (k - 8) -: 8];
    return cal_hi[39 - 8 * (k - 16) -: 8];
  endfunction

  // Raw reading divided by its scale, with FracBits fraction bits.
  function automatic s64_t to_scaled(input logic [RawW-1:0] raw, input logic [23:0] scale);
    logic [63:0] d, num, q;
    d = (scale == 0) ? 64'd1 : 64'(scale);
    num = 64'(raw[23] ? 24'(-raw) : raw) << FracBits;
    if (raw == 24'h800000) num = 64'h80_0000 << FracBits;
    q = (num + d / 2) / d;
    return raw[23] ? -s64_t'(q) : s64_t'(q);
  endfunction

  function automatic logic signed [OutW-1:0] to_out32(input s64_t x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Compensated temperature and pressure for one raw pair.
  function automatic reading_t compensate(input logic [RawW-1:0] raw_p,
                                          input logic [RawW-1:0] raw_t);
    logic signed [11:0] c0, c1, c31, c40;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;
    logic [7:0] b [21];
    s64_t psc, tsc, t, p, inner, p2, p3, p4;
    reading_t r;
    for (int k = 0; k < 21; k++) b[k] = cal_byte(k);
    c0 = {b[0], b[1][7:4]};
    c1 = {b[1][3:0], b[2]};
    c00 = {b[3], b[4], b[5][7:4]};
    c10 = {b[5][3:0], b[6], b[7]};
    c01 = {b[8], b[9]};
    c11 = {b[10], b[11]};
    c20 = {b[12], b[13]};
    c21 = {b[14], b[15]};
    c30 = {b[16], b[17]};
    c31 = {b[18], b[19][7:4]};
    c40 = {b[19][3:0], b[20]};
    psc = to_scaled(raw_p, p_scale);
    tsc = to_scaled(raw_t, t_scale);

    t = add_clamp(s64_t'(c0) <<< (FracBits - 1), mul_round(c1, tsc, 0));

    p2 = mul_round(psc, psc, FracBits);
    p3 = mul_round(p2, psc, FracBits);
    p4 = mul_round(p2, p2, FracBits);

    p = s64_t'(c00) <<< FracBits;
    p = add_clamp(p, mul_round(c10, psc, 0));
    p = add_clamp(p, mul_round(c20, p2, 0));
    p = add_clamp(p, mul_round(c30, p3, 0));
    p = add_clamp(p, mul_round(c40, p4, 0));

    inner = s64_t'(c01) <<< FracBits;
    inner = add_clamp(inner, mul_round(c11, psc, 0));
    inner = add_clamp(inner, mul_round(c21, p2, 0));
    inner = add_clamp(inner, mul_round(c31, p3, 0));
    p = add_clamp(p, mul_round(tsc, inner, FracBits));

    r.temp = to_out32(mul_round(t, 1, FracBits - TempFrac));
    r.press = to_out32(mul_round(p, 1, FracBits - PressFrac));
    return r;
  endfunction

  // Register write that also updates the shadow copy; the block is idle whenever
  // this is called.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_COEF_LO:  cal_lo = data;
      CFG_COEF_MID: cal_mid = data;
      CFG_COEF_HI:  cal_hi = data[39:0];
      CFG_P_SCALE:  p_scale = data[23:0];
      CFG_T_SCALE:  t_scale = data[23:0];
      default: ;
    endcase
    quote_zero = (cal_lo == 0) && (cal_mid == 0) && (cal_hi == 0);
    @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [63:0] lo, input logic [63:0] mid,
                              input logic [63:0] hi, input logic [63:0] ps,
                              input logic [63:0] ts);
    cfg_write(CFG_COEF_LO, lo);
    cfg_write(CFG_COEF_MID, mid);
    cfg_write(CFG_COEF_HI, hi);
    cfg_write(CFG_P_SCALE, ps);
    cfg_write(CFG_T_SCALE, ts);
  endtask

  task automatic wait_drained();
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
  endtask

  // Offer one raw pair and hold it until the block takes it.
  task automatic send_pair(input logic [RawW-1:0] raw_p, input logic [RawW-1:0] raw_t);
    if (sender_idles && $urandom_range(99) < 36) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 36) @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.raw_pressure <= raw_p;
    sample_if.raw_temperature <= raw_t;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  task automatic end_burst();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_scale();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'd1;
      2: return 24'hFFFFFF;
      3: return 24'($urandom);
      4: return 24'd253952;
      5: return 24'd524288;
      6: return 24'd7864320;
      7: return 24'd2088960;
      default: return 24'($urandom_range(24'hFFFFFF, 24'd100000));
    endcase
  endfunction

  // Input monitor: work out the reading for each accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni && sample_if.valid && sample_if.ready) begin
      if (quote_zero) begin
        expected_readings.push_back('{temp: '0, press: '0});
      end else begin
        expected_readings.push_back(compensate(sample_if.raw_pressure,
                                               sample_if.raw_temperature));
      end
    end
  end

  // Output monitor: compare each result with the oldest expected reading.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_readings.size() == 0) begin
        report($sformatf("unexpected result T=%0d P=%0d",
                         result_if.temperature_q16, result_if.pressure_q8));
      end else begin
        want = expected_readings.pop_front();
        if (result_if.temperature_q16 !== want.temp) begin
          report($sformatf("temperature_q16 got %0d want %0d",
                           result_if.temperature_q16, want.temp));
        end
        if (result_if.pressure_q8 !== want.press) begin
          report($sformatf("pressure_q8 got %0d want %0d",
                           result_if.pressure_q8, want.press));
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold when one is requested.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      result_if.ready <= 1'b0;
      hold_request <= hold_request - 1;
    end else begin
      result_if.ready <= !(receiver_idles && $urandom_range(99) < 36);
    end
  end

  initial begin
    #50ms;
    $display("FAIL baro_pressure_temp_compensation");
    $finish;
  end

  initial begin
    logic [23:0] ps, ts;
    errors = 0;
    hold_request = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    cal_lo = '0;
    cal_mid = '0;
    cal_hi = '0;
    p_scale = 24'd253952;
    t_scale = 24'd524288;
    quote_zero = 1'b1;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_COEF_LO;
    cfg_data_i = '0;
    sample_if.valid = 1'b0;
    sample_if.raw_pressure = '0;
    sample_if.raw_temperature = '0;
    result_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients are zero, so every reading must come out zero.
    foreach (corner_rows[i]) send_pair(corner_rows[i].raw_p, corner_rows[i].raw_t);
    end_burst();
    wait_drained();

    // Extreme calibrations; a write to an unused index must be ignored, and
    // bits above a register's width are dropped.
    load_setting({8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, 64'hFFFF_FFFF_FF00_0001, 64'd0);
    cfg_write(CfgIdxUnused, '1);
    foreach (corner_rows[i]) send_pair(corner_rows[i].raw_p, corner_rows[i].raw_t);
    end_burst();
    wait_drained();
    load_setting({8{8'h80}}, {8{8'h80}}, {8{8'hA5}}, 64'd0, 64'hFFFFFF);
    foreach (corner_rows[i]) send_pair(corner_rows[i].raw_p, corner_rows[i].raw_t);
    end_burst();
    wait_drained();
    load_setting('1, '1, '1, 64'd253952, 64'd524288);
    foreach (corner_rows[i]) send_pair(corner_rows[i].raw_p, corner_rows[i].raw_t);
    end_burst();
    wait_drained();

    // Random calibrations and samples.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      ps = pick_scale();
      ts = pick_scale();
      load_setting({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 64'(ps), 64'(ts));
      sender_idles = (ph != 3);
      receiver_idles = (ph != 3);
      if (ph == 5) hold_request = HoldCycles;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (ph == 7 && n == ItemsPerPhase / 2) begin
          end_burst();
          while (expected_readings.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(9) == 0) begin
          send_pair(24'($urandom), 24'($urandom));
        end else begin
          // Mostly readings of sensible magnitude.
          send_pair(24'($signed(20'($urandom))), 24'($signed(20'($urandom))));
        end
      end
      end_burst();
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS baro_pressure_temp_compensation");
    end else begin
      $display("FAIL baro_pressure_temp_compensation");
    end
    $finish;
  end

endmodule
